FILE: rtl/tccs_pkg.sv
// Shared types and constants for the text console cursor/scroll engine.
package tccs_pkg;

    // Request kinds carried on s_axis_tuser
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Character and colour codes
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'h09;
    localparam logic [7:0] BLANK_COLOR  = 8'h00;

    // Cell values written by the sweep engine
    localparam logic [15:0] CLEAR_CELL = {RESET_COLOR, SPACE_CODE};
    localparam logic [15:0] BLANK_CELL = {BLANK_COLOR, SPACE_CODE};

    // Field widths
    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int RROW_W = 5;
    localparam int RCOL_W = 7;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Status of the sweep engine towards the request sequencer
    typedef struct packed {
        logic busy;       // clearing pass or scroll in progress
        logic rd_active;  // sweep owns the RAM read port this cycle
    } sweep_stat_t;

endpackage

FILE: rtl/tccs_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/tccs_sweep.sv
// Sweep engine: clearing pass after reset and the row-up copy of a scroll.
module tccs_sweep #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start_scroll,
    output tccs_pkg::sweep_stat_t            stat,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  rd_addr,
    input  logic [15:0]                      rd_data,
    output logic                             wr_en,
    output logic [$clog2(ROWS*COLUMNS)-1:0]  wr_addr,
    output logic [15:0]                      wr_data
);
    import tccs_pkg::*;

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW  = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(TOTAL - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLEAR,
        S_COPY,
        S_FILL
    } sweep_state_t;

    sweep_state_t  state_reg;
    logic [AW-1:0] idx_reg;
    logic          copy_v_reg;    // copy write pending, data arrives from RAM
    logic [AW-1:0] copy_addr_reg;

    // Sequencer: walk the store one cell per cycle, but the fill waits while the last copy write holds the port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            copy_v_reg <= 1'b0;
        end else begin
            copy_v_reg    <= (state_reg == S_COPY);
            copy_addr_reg <= idx_reg;
            unique case (state_reg)
                S_IDLE: begin
                    if (start_scroll) begin
                        state_reg <= S_COPY;
                        idx_reg   <= '0;
                    end
                end
                S_CLEAR: begin
                    if (idx_reg == LAST_CELL) begin
                        state_reg <= S_IDLE;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_COPY: begin
                    if (idx_reg == LAST_ROW - 1'b1) begin
                        state_reg <= S_FILL;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_FILL: begin
                    // the last copy write takes the port first
                    if (!copy_v_reg) begin
                        if (idx_reg == LAST_CELL) begin
                            state_reg <= S_IDLE;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // RAM port requests
    assign rd_addr = idx_reg + COLS_A;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = BLANK_CELL;
        if (copy_v_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end else if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_data = CLEAR_CELL;
        end else if (state_reg == S_FILL) begin
            wr_en   = 1'b1;
        end
    end

    assign stat.busy      = (state_reg != S_IDLE) || copy_v_reg;
    assign stat.rd_active = (state_reg == S_COPY);

`ifndef SYNTHESIS
    // A scroll never starts on top of a sweep
    assert property (@(posedge aclk) disable iff (!aresetn)
        start_scroll |-> (state_reg == S_IDLE && !copy_v_reg))
        else $error("scroll started while sweep busy");

    // Copy phase writes always trail the read by exactly one row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COPY) |=> (copy_v_reg && copy_addr_reg == $past(idx_reg)))
        else $error("copy write lost its address");

    // The fill phase stays within the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (idx_reg >= LAST_ROW))
        else $error("fill outside bottom row");
`endif

endmodule

FILE: rtl/text_console_cursor_scroll.sv
// Top level of the text console engine: request sequencer, cursor and output register.
//
// A text screen of ROWS x COLUMNS 16-bit cells (attribute in the high byte, character
// in the low byte) held in one RAM, plus a cursor. After reset the block writes 0x0920
// to every cell and takes no request until done; cfg_wr_en/cfg_wr_data may be written
// at any time and set the attribute of later characters. One request is handled at a
// time: a put without scroll goes straight to the result stage, a read first waits for
// the registered RAM read, and a put that scrolls first waits for the sweep that copies
// every row below the top up one row, one cell per cycle, through the single RAM port
// pair and blanks the bottom row. The result register frees the input side while a
// result waits on m_axis_tready.
module text_console_cursor_scroll #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config
    input  logic                             cfg_wr_en,
    input  logic [7:0]                       cfg_wr_data,    // text_color
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code[7:0], read_row[12:8], read_col[19:13], zero pad[23:20]
    input  logic [tccs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tuser,   // kind
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cell_value[15:0], cursor_row[20:16], cursor_col[27:21], scrolled[28], pad[31:29]
    output logic [tccs_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import tccs_pkg::*;

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int AW    = $clog2(TOTAL);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [RW:0]   ROWS_N   = (RW+1)'(ROWS);
    localparam logic [CW:0]   COLS_N   = (CW+1)'(COLUMNS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DONE
    } seq_state_t;

    seq_state_t        state_reg;
    logic [7:0]        text_color_reg;
    logic [RW-1:0]     cur_row_reg;
    logic [CW-1:0]     cur_col_reg;
    logic              in_range_reg;
    logic [CELL_W-1:0] res_cell_reg;
    logic              res_scrolled_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              load_result;

    // request fields
    logic [CHAR_W-1:0] char_code;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_col;
    logic              accept;
    logic              is_put;
    logic              newline;

    // cursor update
    logic [CW:0]       col_inc;
    logic [RW:0]       row_inc;
    logic              wrap;
    logic              row_adv;
    logic              scroll;
    logic [RW-1:0]     cur_row_next;
    logic [CW-1:0]     cur_col_next;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     read_addr;
    logic              read_in_range;
    logic [31:0]       row_ext;
    logic [31:0]       col_ext;

    // RAM and sweep wiring
    sweep_stat_t       sw_stat;
    logic [AW-1:0]     sw_rd_addr;
    logic              sw_wr_en;
    logic [AW-1:0]     sw_wr_addr;
    logic [CELL_W-1:0] sw_wr_data;
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    assign char_code = s_axis_tdata[CHAR_W-1:0];
    assign read_row  = s_axis_tdata[CHAR_W +: RROW_W];
    assign read_col  = s_axis_tdata[CHAR_W+RROW_W +: RCOL_W];

    assign s_axis_tready = (state_reg == ST_IDLE) && !sw_stat.busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_put        = (s_axis_tuser == KIND_PUT);
    assign newline       = (char_code == NEWLINE_CODE);

    // Next cursor position for a put
    always_comb begin
        col_inc = {1'b0, cur_col_reg} + 1'b1;
        row_inc = {1'b0, cur_row_reg} + 1'b1;
        wrap    = !newline && (col_inc == COLS_N);
        row_adv = newline || wrap;
        scroll  = row_adv && (row_inc == ROWS_N);
        cur_col_next = row_adv ? '0 : col_inc[CW-1:0];
        cur_row_next = (row_adv && !scroll) ? row_inc[RW-1:0] : cur_row_reg;
    end

    // Cell addresses
    assign cur_addr      = AW'(cur_row_reg) * COLS_A + AW'(cur_col_reg);
    assign read_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
    assign read_addr     = AW'(read_row) * COLS_A + AW'(read_col);

    // RAM port sharing: the sweep takes the read port while copying and the write port whenever it writes
    assign ram_rd_addr = sw_stat.rd_active ? sw_rd_addr : read_addr;
    assign ram_wr_en   = sw_wr_en || (accept && is_put && !newline);
    assign ram_wr_addr = sw_wr_en ? sw_wr_addr : cur_addr;
    assign ram_wr_data = sw_wr_en ? sw_wr_data : {text_color_reg, char_code};

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (TOTAL)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tccs_sweep #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_sweep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_scroll (accept && is_put && scroll),
        .stat         (sw_stat),
        .rd_addr      (sw_rd_addr),
        .rd_data      (ram_rd_data),
        .wr_en        (sw_wr_en),
        .wr_addr      (sw_wr_addr),
        .wr_data      (sw_wr_data)
    );

    // Colour register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg <= RESET_COLOR;
        end else if (cfg_wr_en) begin
            text_color_reg <= cfg_wr_data;
        end
    end

    // Output field views of the cursor, masked to the field widths
    assign row_ext = 32'(cur_row_reg);
    assign col_ext = 32'(cur_col_reg);

    // Result register loads once the output slot is free
    assign load_result = (state_reg == ST_DONE) && (!m_tvalid_reg || m_axis_tready);

    // Request sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_row_reg  <= '0;
            cur_col_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_axis_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        in_range_reg     <= read_in_range;
                        res_cell_reg     <= '0;
                        res_scrolled_reg <= is_put && scroll;
                        if (is_put) begin
                            cur_row_reg      <= cur_row_next;
                            cur_col_reg      <= cur_col_next;
                            state_reg        <= scroll ? ST_SCROLL : ST_DONE;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    res_cell_reg <= in_range_reg ? ram_rd_data : '0;
                    state_reg    <= ST_DONE;
                end
                ST_SCROLL: begin
                    if (!sw_stat.busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_result) begin
                        m_tdata_reg  <= {3'b000, res_scrolled_reg, col_ext[RCOL_W-1:0],
                                         row_ext[RROW_W-1:0], res_cell_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // No request is taken while the sweep owns the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |-> !sw_stat.busy)
        else $error("request accepted during sweep");

    // Cursor stays on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(cur_row_reg) < ROWS) && (32'(cur_col_reg) < COLUMNS))
        else $error("cursor off screen");

    // A scrolled put leaves the cursor on the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_scrolled_reg) |-> (32'(cur_row_reg) == ROWS - 1))
        else $error("scroll left cursor above bottom row");

    // A finished scroll hands over to the result stage next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL && !sw_stat.busy) |=> (state_reg == ST_DONE))
        else $error("scroll did not complete");
`endif

endmodule
